### src/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants, codes and controller/datapath interface types for the
// line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int LEN_W        = $clog2(BUFFER_DEPTH);
    localparam int CAP_W        = 6;
    localparam int OP_W         = 3;
    localparam int CHAR_W       = 8;
    localparam int OUT_W        = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd63;

    localparam logic [OP_W-1:0] OP_TYPE  = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd1;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_HOME  = 3'd4;
    localparam logic [OP_W-1:0] OP_END   = 3'd5;
    localparam logic [OP_W-1:0] OP_PRINT = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS,
        S_DEL,
        S_PRN
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REFUSE,
        CMD_MOVE,
        CMD_INS_STEP,
        CMD_INS_CHAR,
        CMD_DEL_STEP,
        CMD_DEL_DONE,
        CMD_PRN_STEP
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            can_type;
        logic            can_erase;
        logic            ins_more;
        logic            del_more;
        logic            prn_last;
        logic            pend;
    } status_t;

endpackage

### src/leb_ram.sv
// ----------------------------------------------------------------------------
// leb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl
// Controller state machine: sequences shift, insert, delete and print steps.
// ----------------------------------------------------------------------------
module leb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  leb_pkg::status_t status,
    output leb_pkg::cmd_t    cmd,
    output logic             busy
);

    leb_pkg::state_t state_reg;
    leb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= leb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = leb_pkg::CMD_NONE;
        busy       = 1'b1;
        case (state_reg)
            leb_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd        = leb_pkg::CMD_LOAD;
                    state_next = leb_pkg::S_DISPATCH;
                end
            end
            leb_pkg::S_DISPATCH:
            begin
                case (status.op)
                    leb_pkg::OP_TYPE:
                    begin
                        if (status.can_type)
                        begin
                            state_next = leb_pkg::S_INS;
                        end
                        else
                        begin
                            cmd        = leb_pkg::CMD_REFUSE;
                            state_next = leb_pkg::S_IDLE;
                        end
                    end
                    leb_pkg::OP_ERASE:
                    begin
                        if (status.can_erase)
                        begin
                            state_next = leb_pkg::S_DEL;
                        end
                        else
                        begin
                            cmd        = leb_pkg::CMD_REFUSE;
                            state_next = leb_pkg::S_IDLE;
                        end
                    end
                    leb_pkg::OP_PRINT:
                    begin
                        state_next = leb_pkg::S_PRN;
                    end
                    default:
                    begin
                        cmd        = leb_pkg::CMD_MOVE;
                        state_next = leb_pkg::S_IDLE;
                    end
                endcase
            end
            leb_pkg::S_INS:
            begin
                if (status.ins_more || status.pend)
                begin
                    cmd = leb_pkg::CMD_INS_STEP;
                end
                else
                begin
                    cmd        = leb_pkg::CMD_INS_CHAR;
                    state_next = leb_pkg::S_IDLE;
                end
            end
            leb_pkg::S_DEL:
            begin
                if (status.del_more || status.pend)
                begin
                    cmd = leb_pkg::CMD_DEL_STEP;
                end
                else
                begin
                    cmd        = leb_pkg::CMD_DEL_DONE;
                    state_next = leb_pkg::S_IDLE;
                end
            end
            leb_pkg::S_PRN:
            begin
                cmd = leb_pkg::CMD_PRN_STEP;
                if (status.prn_last)
                begin
                    state_next = leb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = leb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### src/leb_datapath.sv
// ----------------------------------------------------------------------------
// leb_datapath
// Text store, length and cursor registers, shift pointer and result stage.
// ----------------------------------------------------------------------------
module leb_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  leb_pkg::cmd_t               cmd,
    output leb_pkg::status_t            status,
    input  logic [leb_pkg::OP_W-1:0]    operation,
    input  logic [leb_pkg::CHAR_W-1:0]  char_value,
    input  logic                        cfg_valid,
    input  logic [leb_pkg::CAP_W-1:0]   cfg_data,
    output logic                        result_valid,
    output logic                        ok,
    output logic [leb_pkg::CHAR_W-1:0]  text_char,
    output logic                        is_last,
    output logic [leb_pkg::OUT_W-1:0]   line_length,
    output logic [leb_pkg::OUT_W-1:0]   cursor_position
);

    localparam logic [leb_pkg::LEN_W-1:0] LEN_MAX = leb_pkg::LEN_W'(leb_pkg::BUFFER_DEPTH - 1);
    localparam logic [leb_pkg::LEN_W-1:0] LEN_ONE = leb_pkg::LEN_W'(1);

    logic [leb_pkg::CAP_W-1:0]  capacity_reg;
    logic [leb_pkg::LEN_W-1:0]  length_reg, length_next;
    logic [leb_pkg::LEN_W-1:0]  cursor_reg, cursor_next;
    logic                       pend_reg, pend_next;
    logic                       res_valid_reg, res_valid_next;

    logic [leb_pkg::OP_W-1:0]   op_reg, op_next;
    logic [leb_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [leb_pkg::LEN_W-1:0]  ptr_reg, ptr_next;
    logic [leb_pkg::LEN_W-1:0]  pend_addr_reg, pend_addr_next;
    logic                       res_ok_reg, res_ok_next;
    logic                       res_last_reg, res_last_next;
    logic                       res_ram_reg, res_ram_next;
    logic [leb_pkg::CHAR_W-1:0] res_char_reg, res_char_next;

    logic                       ram_we;
    logic [leb_pkg::LEN_W-1:0]  ram_waddr;
    logic [leb_pkg::CHAR_W-1:0] ram_wdata;
    logic [leb_pkg::LEN_W-1:0]  ram_raddr;
    logic [leb_pkg::CHAR_W-1:0] ram_rdata;

    leb_ram #(
        .WIDTH (leb_pkg::CHAR_W),
        .DEPTH (leb_pkg::BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.op        = op_reg;
    assign status.can_type  = (leb_pkg::CAP_W'(length_reg) < capacity_reg)
                              && (length_reg < LEN_MAX);
    assign status.can_erase = (cursor_reg != '0);
    assign status.ins_more  = (ptr_reg > cursor_reg);
    assign status.del_more  = (ptr_reg < length_reg);
    assign status.prn_last  = (ptr_reg == length_reg);
    assign status.pend      = pend_reg;

    always_comb
    begin
        length_next    = length_reg;
        cursor_next    = cursor_reg;
        pend_next      = pend_reg;
        res_valid_next = 1'b0;
        op_next        = op_reg;
        char_next      = char_reg;
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        res_ok_next    = res_ok_reg;
        res_last_next  = res_last_reg;
        res_ram_next   = res_ram_reg;
        res_char_next  = res_char_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = ptr_reg;
        case (cmd)
            leb_pkg::CMD_LOAD:
            begin
                op_next   = operation;
                char_next = char_value;
                pend_next = 1'b0;
                case (operation)
                    leb_pkg::OP_TYPE:  ptr_next = length_reg;
                    leb_pkg::OP_ERASE: ptr_next = cursor_reg;
                    default:           ptr_next = '0;
                endcase
            end
            leb_pkg::CMD_REFUSE:
            begin
                res_valid_next = 1'b1;
                res_ok_next    = 1'b0;
                res_last_next  = 1'b1;
                res_ram_next   = 1'b0;
                res_char_next  = '0;
            end
            leb_pkg::CMD_MOVE:
            begin
                res_valid_next = 1'b1;
                res_ok_next    = 1'b0;
                res_last_next  = 1'b1;
                res_ram_next   = 1'b0;
                res_char_next  = '0;
                case (op_reg)
                    leb_pkg::OP_LEFT:
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - LEN_ONE;
                        end
                    end
                    leb_pkg::OP_RIGHT:
                    begin
                        if (cursor_reg < length_reg)
                        begin
                            cursor_next = cursor_reg + LEN_ONE;
                        end
                    end
                    leb_pkg::OP_HOME: cursor_next = '0;
                    leb_pkg::OP_END:  cursor_next = length_reg;
                    default:          cursor_next = cursor_reg;
                endcase
            end
            leb_pkg::CMD_INS_STEP:
            begin
                ram_we = pend_reg;
                if (ptr_reg > cursor_reg)
                begin
                    ram_raddr      = ptr_reg - LEN_ONE;
                    pend_addr_next = ptr_reg;
                    pend_next      = 1'b1;
                    ptr_next       = ptr_reg - LEN_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            leb_pkg::CMD_INS_CHAR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = cursor_reg;
                ram_wdata      = char_reg;
                length_next    = length_reg + LEN_ONE;
                cursor_next    = cursor_reg + LEN_ONE;
                res_valid_next = 1'b1;
                res_ok_next    = 1'b1;
                res_last_next  = 1'b1;
                res_ram_next   = 1'b0;
                res_char_next  = '0;
            end
            leb_pkg::CMD_DEL_STEP:
            begin
                ram_we = pend_reg;
                if (ptr_reg < length_reg)
                begin
                    ram_raddr      = ptr_reg;
                    pend_addr_next = ptr_reg - LEN_ONE;
                    pend_next      = 1'b1;
                    ptr_next       = ptr_reg + LEN_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            leb_pkg::CMD_DEL_DONE:
            begin
                length_next    = length_reg - LEN_ONE;
                cursor_next    = cursor_reg - LEN_ONE;
                res_valid_next = 1'b1;
                res_ok_next    = 1'b1;
                res_last_next  = 1'b1;
                res_ram_next   = 1'b0;
                res_char_next  = '0;
            end
            leb_pkg::CMD_PRN_STEP:
            begin
                // result k is the marker at the cursor, else the character shifted past it
                res_valid_next = 1'b1;
                res_ok_next    = 1'b0;
                res_last_next  = (ptr_reg == length_reg);
                res_char_next  = char_reg;
                res_ram_next   = (ptr_reg != cursor_reg);
                if (ptr_reg < cursor_reg)
                begin
                    ram_raddr = ptr_reg;
                end
                else
                begin
                    ram_raddr = ptr_reg - LEN_ONE;
                end
                ptr_next = ptr_reg + LEN_ONE;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= leb_pkg::CAP_RESET;
            length_reg    <= '0;
            cursor_reg    <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            length_reg    <= length_next;
            cursor_reg    <= cursor_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        char_reg      <= char_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        res_ok_reg    <= res_ok_next;
        res_last_reg  <= res_last_next;
        res_ram_reg   <= res_ram_next;
        res_char_reg  <= res_char_next;
    end

    assign result_valid    = res_valid_reg;
    assign ok              = res_ok_reg;
    assign is_last         = res_last_reg;
    assign text_char       = res_ram_reg ? ram_rdata : res_char_reg;
    assign line_length     = leb_pkg::OUT_W'(length_reg);
    assign cursor_position = leb_pkg::OUT_W'(cursor_reg);

endmodule

### src/line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_unit
// One-line text buffer with a cursor, driven by key event requests.
// ----------------------------------------------------------------------------
// usage
//   request channel: operation and char_value are taken at a clock edge with
//   start high and busy low. busy stays high until the request is finished.
//   results: each result is on the result ports for one cycle, marked by
//   result_valid; is_last flags the final result of a request. the receiver
//   cannot stall the block, so it must take every strobed result.
//   capacity: written through cfg_valid/cfg_data (cfg_ready is always high),
//   by the user only while the block is idle; the block does not enforce it.
// sequences: the text store has one read and one write port and moves one
//   character per cycle during shifts and prints.
//   left, right, home, end, unused code, refused type or erase: one result
//   type: characters right of the cursor shift one place right, then the new
//     character is written at the cursor; one result
//   erase: characters right of the cursor shift one place left; one result
//   print: line length + 1 results, one per cycle, cursor marker included
// reset: line length and cursor go to zero, capacity to 63. the text store
//   is not cleared; only entries below the line length are ever read.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [leb_pkg::OP_W-1:0]    operation,
    input  logic [leb_pkg::CHAR_W-1:0]  char_value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [leb_pkg::CAP_W-1:0]   cfg_data,
    output logic                        result_valid,
    output logic                        ok,
    output logic [leb_pkg::CHAR_W-1:0]  text_char,
    output logic                        is_last,
    output logic [leb_pkg::OUT_W-1:0]   line_length,
    output logic [leb_pkg::OUT_W-1:0]   cursor_position
);

    leb_pkg::cmd_t    cmd;
    leb_pkg::status_t status;

    assign cfg_ready = 1'b1;

    leb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    leb_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .char_value      (char_value),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .ok              (ok),
        .text_char       (text_char),
        .is_last         (is_last),
        .line_length     (line_length),
        .cursor_position (cursor_position)
    );

    // accepted request keeps the block busy for its work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted request");

    // a print run has no gaps
    a_print_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_last |=> result_valid)
        else $error("gap inside print run");

    // successful edits give a single result
    a_ok_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ok |-> is_last)
        else $error("ok on a non-final result");

    // cursor stays within the line
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_position <= line_length)
        else $error("cursor beyond line end");

    // line never outgrows the store
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_length <= leb_pkg::OUT_W'(leb_pkg::BUFFER_DEPTH - 1))
        else $error("line length beyond store");

endmodule

### test/line_edit_buffer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer_unit_test
// Self-checking bench for the line edit buffer. Key event requests are driven
// through the start/busy channel with random gaps. A scoreboard class keeps its
// own copy of the line, cursor and capacity, predicts every strobed result and
// checks each field. Capacity is rewritten between phases, including 0 and 63.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit_test;

    localparam logic [leb_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic                       ok;
        logic [leb_pkg::CHAR_W-1:0] chr;
        logic                       last;
        logic [leb_pkg::OUT_W-1:0]  len;
        logic [leb_pkg::OUT_W-1:0]  cur;
    } line_result_t;

    class line_scoreboard;
        logic [leb_pkg::CHAR_W-1:0] held_chars [leb_pkg::BUFFER_DEPTH];
        logic [leb_pkg::OUT_W-1:0]  held_len;
        logic [leb_pkg::OUT_W-1:0]  cursor_at;
        logic [leb_pkg::CAP_W-1:0]  cap_limit;
        line_result_t               expected_results [$];
        int                         mismatch_count;
        int                         request_count;
        int                         result_count;
        int                         print_count;
        int                         refused_types;

        function new();
            held_len       = '0;
            cursor_at      = '0;
            cap_limit      = leb_pkg::CAP_RESET;
            mismatch_count = 0;
            request_count  = 0;
            result_count   = 0;
            print_count    = 0;
            refused_types  = 0;
        endfunction

        function void push_result(logic ok_bit, logic [leb_pkg::CHAR_W-1:0] chr, logic last);
            line_result_t r;
            r.ok   = ok_bit;
            r.chr  = chr;
            r.last = last;
            r.len  = held_len;
            r.cur  = cursor_at;
            expected_results.push_back(r);
        endfunction

        function void note_request(logic [leb_pkg::OP_W-1:0] op,
                                   logic [leb_pkg::CHAR_W-1:0] chr);
            logic ok_bit;
            int   i;
            int   k;
            ok_bit = 1'b0;
            request_count++;
            case (op)
                leb_pkg::OP_TYPE:
                    if (int'(held_len) < int'(cap_limit)
                        && int'(held_len) < leb_pkg::BUFFER_DEPTH - 1)
                    begin
                        for (i = int'(held_len); i > int'(cursor_at); i--)
                            held_chars[i] = held_chars[i-1];
                        held_chars[cursor_at] = chr;
                        held_len++;
                        cursor_at++;
                        ok_bit = 1'b1;
                    end
                    else
                    begin
                        refused_types++;
                    end
                leb_pkg::OP_ERASE:
                    if (cursor_at != 0)
                    begin
                        for (i = int'(cursor_at); i < int'(held_len); i++)
                            held_chars[i-1] = held_chars[i];
                        held_len--;
                        cursor_at--;
                        ok_bit = 1'b1;
                    end
                leb_pkg::OP_LEFT:
                    if (cursor_at != 0)
                        cursor_at--;
                leb_pkg::OP_RIGHT:
                    if (cursor_at < held_len)
                        cursor_at++;
                leb_pkg::OP_HOME:
                    cursor_at = '0;
                leb_pkg::OP_END:
                    cursor_at = held_len;
                leb_pkg::OP_PRINT:
                begin
                    print_count++;
                    k = 0;
                    for (i = 0; i <= int'(held_len); i++)
                    begin
                        if (i == int'(cursor_at))
                        begin
                            k++;
                            push_result(1'b0, chr, k == int'(held_len) + 1);
                        end
                        if (i < int'(held_len))
                        begin
                            k++;
                            push_result(1'b0, held_chars[i], k == int'(held_len) + 1);
                        end
                    end
                    return;
                end
                default: ;
            endcase
            push_result(ok_bit, '0, 1'b1);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t ns: mismatch on %s: got %0d, expected %0d",
                         $time, what, got, want);
        endtask

        task check_result(line_result_t got);
            line_result_t want;
            result_count++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok)
                report_mismatch("ok", got.ok, want.ok);
            if (got.chr !== want.chr)
                report_mismatch("text_char", got.chr, want.chr);
            if (got.last !== want.last)
                report_mismatch("is_last", got.last, want.last);
            if (got.len !== want.len)
                report_mismatch("line_length", got.len, want.len);
            if (got.cur !== want.cur)
                report_mismatch("cursor_position", got.cur, want.cur);
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [leb_pkg::OP_W-1:0]   operation = '0;
    logic [leb_pkg::CHAR_W-1:0] char_value = '0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [leb_pkg::CAP_W-1:0]  cfg_data = '0;
    logic                       result_valid;
    logic                       ok;
    logic [leb_pkg::CHAR_W-1:0] text_char;
    logic                       is_last;
    logic [leb_pkg::OUT_W-1:0]  line_length;
    logic [leb_pkg::OUT_W-1:0]  cursor_position;

    line_scoreboard sb = new();
    logic           steady = 1'b0;

    line_edit_buffer_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .char_value      (char_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .ok              (ok),
        .text_char       (text_char),
        .is_last         (is_last),
        .line_length     (line_length),
        .cursor_position (cursor_position)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.cap_limit = cfg_data;
            if (start && !busy)
                sb.note_request(operation, char_value);
            if (result_valid)
                sb.check_result({ok, text_char, is_last, line_length, cursor_position});
        end
    end

    task send_request(logic [leb_pkg::OP_W-1:0] op, logic [leb_pkg::CHAR_W-1:0] chr);
        int gap;
        if (!steady && $urandom_range(0, 99) < 18)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        char_value <= chr;
        do
            @(posedge clk);
        while (busy);
    endtask

    task wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_capacity(logic [leb_pkg::CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function logic [leb_pkg::OP_W-1:0] pick_operation(int type_weight);
        int r;
        if ($urandom_range(0, 99) < type_weight)
            return leb_pkg::OP_TYPE;
        r = $urandom_range(0, 50);
        if (r < 15)
            return leb_pkg::OP_ERASE;
        if (r < 23)
            return leb_pkg::OP_LEFT;
        if (r < 31)
            return leb_pkg::OP_RIGHT;
        if (r < 35)
            return leb_pkg::OP_HOME;
        if (r < 39)
            return leb_pkg::OP_END;
        if (r < 49)
            return leb_pkg::OP_PRINT;
        return OP_UNUSED;
    endfunction

    initial
    begin
        int                       phase_caps [7];
        int                       phase_items [7];
        int                       phase_type [7];
        int                       p;
        int                       n;
        logic [leb_pkg::OP_W-1:0] op;

        phase_caps  = '{63, 0, 7, 1, 62, 33, 63};
        phase_items = '{80, 35, 40, 35, 40, 40, 40};
        phase_type  = '{85, 20, 50, 45, 60, 45, 50};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: bounds, every operation, insert in the middle, empty line
        write_capacity(6'd63);
        send_request(leb_pkg::OP_PRINT, 8'h00);
        send_request(leb_pkg::OP_ERASE, 8'h00);
        send_request(leb_pkg::OP_LEFT, 8'h00);
        send_request(leb_pkg::OP_RIGHT, 8'hFF);
        send_request(OP_UNUSED, 8'hFF);
        send_request(leb_pkg::OP_TYPE, 8'h00);
        send_request(leb_pkg::OP_TYPE, 8'hFF);
        send_request(leb_pkg::OP_TYPE, 8'h41);
        send_request(leb_pkg::OP_LEFT, 8'h00);
        send_request(leb_pkg::OP_LEFT, 8'h00);
        send_request(leb_pkg::OP_TYPE, 8'h5A);
        send_request(leb_pkg::OP_HOME, 8'h00);
        send_request(leb_pkg::OP_TYPE, 8'h7C);
        send_request(leb_pkg::OP_ERASE, 8'h00);
        send_request(leb_pkg::OP_TYPE, 8'h7C);
        send_request(leb_pkg::OP_END, 8'h00);
        send_request(leb_pkg::OP_RIGHT, 8'h00);
        send_request(leb_pkg::OP_LEFT, 8'h00);
        send_request(leb_pkg::OP_ERASE, 8'h00);
        send_request(leb_pkg::OP_PRINT, 8'hFF);
        send_request(leb_pkg::OP_HOME, 8'h00);
        send_request(leb_pkg::OP_PRINT, 8'h7C);

        // capacity below the held length
        wait_idle();
        write_capacity(6'd2);
        send_request(leb_pkg::OP_TYPE, 8'h33);
        send_request(leb_pkg::OP_END, 8'h00);
        send_request(leb_pkg::OP_ERASE, 8'h00);
        send_request(leb_pkg::OP_ERASE, 8'h00);
        send_request(leb_pkg::OP_TYPE, 8'h55);
        send_request(leb_pkg::OP_PRINT, 8'hAA);

        for (p = 0; p < 7; p++)
        begin
            wait_idle();
            write_capacity(leb_pkg::CAP_W'(phase_caps[p]));
            steady = (p == 3);
            for (n = 0; n < phase_items[p]; n++)
            begin
                op = pick_operation(phase_type[p]);
                send_request(op, leb_pkg::CHAR_W'($urandom_range(0, 255)));
            end
        end
        steady = 1'b0;

        wait_idle();
        repeat (16) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d prints, %0d refused types",
                 sb.request_count, sb.result_count, sb.print_count, sb.refused_types);
        $display("capacity settings 63, 2, 0, 7, 1, 62, 33; %0d mismatches",
                 sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
